### design/dtf_pkg.sv
package dtf_pkg;

    // Input item opcodes carried on the slave tuser.
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Result kinds carried on the master tuser.
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Conversion codes and fixed characters.
    localparam logic [7:0] CODE_PCT  = 8'h25;
    localparam logic [7:0] CODE_LA   = 8'h61;
    localparam logic [7:0] CODE_UA   = 8'h41;
    localparam logic [7:0] CODE_LB   = 8'h62;
    localparam logic [7:0] CODE_UB   = 8'h42;
    localparam logic [7:0] CODE_LC   = 8'h63;
    localparam logic [7:0] CODE_LD   = 8'h64;
    localparam logic [7:0] CODE_UH   = 8'h48;
    localparam logic [7:0] CODE_UI   = 8'h49;
    localparam logic [7:0] CODE_LJ   = 8'h6A;
    localparam logic [7:0] CODE_LM   = 8'h6D;
    localparam logic [7:0] CODE_UM   = 8'h4D;
    localparam logic [7:0] CODE_LP   = 8'h70;
    localparam logic [7:0] CODE_US   = 8'h53;
    localparam logic [7:0] CODE_UU   = 8'h55;
    localparam logic [7:0] CODE_LW   = 8'h77;
    localparam logic [7:0] CODE_UW   = 8'h57;
    localparam logic [7:0] CODE_LX   = 8'h78;
    localparam logic [7:0] CODE_UX   = 8'h58;
    localparam logic [7:0] CODE_LY   = 8'h79;
    localparam logic [7:0] CODE_UY   = 8'h59;
    localparam logic [7:0] CODE_UZ   = 8'h5A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;

    localparam logic [13:0] YEAR_BASE = 14'd1900;
    localparam int          BCD_STEPS = 14;

    typedef enum logic [2:0] {
        S_CONV_START,
        S_CONV_WAIT,
        S_IDLE,
        S_EMIT,
        S_REPORT
    } t_state;

    typedef enum logic [1:0] {
        MODE_LIT,
        MODE_EXP,
        MODE_DANGLE
    } t_mode;

    typedef struct packed {
        logic in_ready;
        logic conv_start;
        logic emit;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic go_conv;
        logic go_emit;
        logic go_report;
        logic conv_busy;
        logic out_free;
        logic step_end;
        logic to_report;
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic [3:0] len;
        logic       fin;
    } t_info;

    function automatic logic [71:0] day_text(input logic [2:0] idx);
        case (idx)
            3'd0: return {"Sunday", 24'h0};
            3'd1: return {"Monday", 24'h0};
            3'd2: return {"Tuesday", 16'h0};
            3'd3: return "Wednesday";
            3'd4: return {"Thursday", 8'h0};
            3'd5: return {"Friday", 24'h0};
            default: return {"Saturday", 8'h0};
        endcase
    endfunction

    function automatic logic [3:0] day_len(input logic [2:0] idx);
        case (idx)
            3'd0: return 4'd6;
            3'd1: return 4'd6;
            3'd2: return 4'd7;
            3'd3: return 4'd9;
            3'd4: return 4'd8;
            3'd5: return 4'd6;
            default: return 4'd8;
        endcase
    endfunction

    function automatic logic [71:0] month_text(input logic [3:0] idx);
        case (idx)
            4'd0:  return {"January", 16'h0};
            4'd1:  return {"February", 8'h0};
            4'd2:  return {"March", 32'h0};
            4'd3:  return {"April", 32'h0};
            4'd4:  return {"May", 48'h0};
            4'd5:  return {"June", 40'h0};
            4'd6:  return {"July", 40'h0};
            4'd7:  return {"August", 24'h0};
            4'd8:  return "September";
            4'd9:  return {"October", 16'h0};
            4'd10: return {"November", 8'h0};
            default: return {"December", 8'h0};
        endcase
    endfunction

    function automatic logic [3:0] month_len(input logic [3:0] idx);
        case (idx)
            4'd0:  return 4'd7;
            4'd1:  return 4'd8;
            4'd2:  return 4'd5;
            4'd3:  return 4'd5;
            4'd4:  return 4'd3;
            4'd5:  return 4'd4;
            4'd6:  return 4'd4;
            4'd7:  return 4'd6;
            4'd8:  return 4'd9;
            4'd9:  return 4'd7;
            4'd10: return 4'd8;
            default: return 4'd8;
        endcase
    endfunction

    function automatic logic [7:0] name_byte(input logic [71:0] s, input logic [3:0] p);
        logic [71:0] t;
        t = s << {p, 3'b000};
        return t[71:64];
    endfunction

endpackage

### design/dtf_bcd.sv
module dtf_bcd
    import dtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [13:0] i_value,
    output logic [19:0] o_bcd,
    output logic        o_busy
);

    logic [13:0] r_bin;
    logic [19:0] r_bcd;
    logic [19:0] n_adj;
    logic [3:0]  r_count;
    logic        r_busy;

    // Shift-and-add-three: every digit of five or more gets three before the shift.
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                         : r_bcd[4*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= 4'd0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= 4'd0;
        end else if (r_busy) begin
            r_count <= r_count + 4'd1;
            if (r_count == 4'(BCD_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= 20'd0;
        end else if (r_busy) begin
            r_bin <= {r_bin[12:0], 1'b0};
            r_bcd <= {n_adj[18:0], r_bin[13]};
        end
    end

    assign o_bcd  = r_bcd;
    assign o_busy = r_busy;

endmodule

### design/dtf_ctrl.sv
module dtf_ctrl
    import dtf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CONV_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CONV_START: n_state = S_CONV_WAIT;
            S_CONV_WAIT: begin
                if (!i_st.conv_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_st.go_conv)        n_state = S_CONV_START;
                else if (i_st.go_emit)   n_state = S_EMIT;
                else if (i_st.go_report) n_state = S_REPORT;
            end
            S_EMIT: begin
                if (i_st.out_free && i_st.step_end) begin
                    n_state = i_st.to_report ? S_REPORT : S_IDLE;
                end
            end
            S_REPORT: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CONV_START: o_cmd.conv_start = 1'b1;
            S_IDLE:       o_cmd.in_ready   = 1'b1;
            S_EMIT:       o_cmd.emit       = i_st.out_free;
            S_REPORT:     o_cmd.report     = i_st.out_free;
            default:      o_cmd = '0;
        endcase
    end

endmodule

### design/dtf_datapath.sv
module dtf_datapath
    import dtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    input  logic        i_s_tvalid,
    input  logic [79:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int L_YEAR = 0;
    localparam int L_YDAY = 1;
    localparam int L_SEC  = 2;
    localparam int L_MIN  = 3;
    localparam int L_HOUR = 4;
    localparam int L_HR12 = 5;
    localparam int L_MDAY = 6;
    localparam int L_MON  = 7;
    localparam int L_WKU  = 8;
    localparam int L_WKM  = 9;
    localparam int LANES  = 10;

    // Held time fields.
    logic [5:0]  r_sec, r_min;
    logic [4:0]  r_hour, r_mday;
    logic [3:0]  r_mon;
    logic [12:0] r_year;
    logic [2:0]  r_wday;
    logic [8:0]  r_yday;
    logic [15:0] r_cap, r_room;
    logic        r_pending, r_ovf;

    // Item sequencing.
    t_mode       r_mode;
    logic [7:0]  r_code;
    logic [4:0]  r_pos;

    // Output register.
    logic        r_out_valid, r_out_kind, r_out_ovf, r_out_last;
    logic [7:0]  r_out_char;
    logic [15:0] r_out_len;

    logic        w_acc;
    logic [1:0]  w_op;
    logic [7:0]  w_ch;
    logic [13:0] w_lane_in [LANES];
    logic [19:0] w_bcd [LANES];
    logic [LANES-1:0] w_busy;
    logic [4:0]  w_hr12;
    logic [9:0]  w_xu, w_xw;
    logic [18:0] w_pu, w_pw;
    logic [2:0]  w_wmon;
    logic [2:0]  w_day_idx;
    logic [3:0]  w_mon_idx;
    logic [71:0] w_day_str, w_mon_str;
    logic [3:0]  w_day_len, w_mon_len;
    t_info       w_cur, w_nxt;
    logic        w_fit, w_emit_char;
    logic [15:0] w_room_after;

    assign w_acc = i_cmd.in_ready & i_s_tvalid;
    assign w_op  = i_s_tuser;
    assign w_ch  = i_s_tdata[7:0];

    // Lane operands, from the held fields.
    always_comb begin
        w_hr12 = (r_hour >= 5'd24) ? r_hour - 5'd24 :
                 (r_hour >= 5'd12) ? r_hour - 5'd12 : r_hour;
        if (w_hr12 == 5'd0) w_hr12 = 5'd12;
        case (r_wday)
            3'd0:    w_wmon = 3'd6;
            3'd7:    w_wmon = 3'd6;
            default: w_wmon = r_wday - 3'd1;
        endcase
        // Division by seven as a multiply by 293 / 2048, exact below 519.
        w_xu = {1'b0, r_yday} + 10'd7 - {7'd0, r_wday};
        w_xw = {1'b0, r_yday} + 10'd7 - {7'd0, w_wmon};
        w_pu = {9'd0, w_xu} * 19'd293;
        w_pw = {9'd0, w_xw} * 19'd293;
        w_lane_in[L_YEAR] = {1'b0, r_year} + YEAR_BASE;
        w_lane_in[L_YDAY] = {5'd0, r_yday} + 14'd1;
        w_lane_in[L_SEC]  = {8'd0, r_sec};
        w_lane_in[L_MIN]  = {8'd0, r_min};
        w_lane_in[L_HOUR] = {9'd0, r_hour};
        w_lane_in[L_HR12] = {9'd0, w_hr12};
        w_lane_in[L_MDAY] = {9'd0, r_mday};
        w_lane_in[L_MON]  = {10'd0, r_mon} + 14'd1;
        w_lane_in[L_WKU]  = {6'd0, w_pu[18:11]};
        w_lane_in[L_WKM]  = {6'd0, w_pw[18:11]};
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        dtf_bcd u_bcd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.conv_start),
            .i_value (w_lane_in[g]),
            .o_bcd   (w_bcd[g]),
            .o_busy  (w_busy[g])
        );
    end

    assign w_day_idx = (r_wday == 3'd7) ? 3'd0 : r_wday;
    assign w_mon_idx = (r_mon >= 4'd12) ? r_mon - 4'd12 : r_mon;
    assign w_day_str = day_text(w_day_idx);
    assign w_mon_str = month_text(w_mon_idx);
    assign w_day_len = day_len(w_day_idx);
    assign w_mon_len = month_len(w_mon_idx);

    function automatic logic [7:0] dig(input int lane, input int k);
        return CH_ZERO + {4'd0, w_bcd[lane][4*k +: 4]};
    endfunction

    // Character, piece start, piece length and last-piece flag at one position of the current item.
    function automatic t_info info_at(input logic [4:0] pos);
        t_info r;
        r = '{ch: CH_SPACE, start: 1'b0, len: 4'd1, fin: 1'b0};
        case (r_mode)
            MODE_LIT: begin
                r.ch = r_code; r.start = 1'b1; r.fin = 1'b1;
            end
            MODE_DANGLE: begin
                r.ch = CODE_PCT; r.start = 1'b1; r.fin = 1'b1;
            end
            default: begin
                case (r_code)
                    CODE_PCT: begin
                        r.ch = CODE_PCT; r.start = 1'b1; r.fin = 1'b1;
                    end
                    CODE_LA, CODE_UA: begin
                        r.ch    = name_byte(w_day_str, pos[3:0]);
                        r.start = (pos == 5'd0);
                        r.len   = (r_code == CODE_LA) ? 4'd3 : w_day_len;
                        r.fin   = (pos == {1'b0, r.len} - 5'd1);
                    end
                    CODE_LB, CODE_UB: begin
                        r.ch    = name_byte(w_mon_str, pos[3:0]);
                        r.start = (pos == 5'd0);
                        r.len   = (r_code == CODE_LB) ? 4'd3 : w_mon_len;
                        r.fin   = (pos == {1'b0, r.len} - 5'd1);
                    end
                    CODE_LD, CODE_UH, CODE_UI, CODE_LM, CODE_UM, CODE_US,
                    CODE_UU, CODE_UW, CODE_LY: begin
                        int ln;
                        case (r_code)
                            CODE_LD: ln = L_MDAY;
                            CODE_UH: ln = L_HOUR;
                            CODE_UI: ln = L_HR12;
                            CODE_LM: ln = L_MON;
                            CODE_UM: ln = L_MIN;
                            CODE_US: ln = L_SEC;
                            CODE_UU: ln = L_WKU;
                            CODE_UW: ln = L_WKM;
                            default: ln = L_YEAR;
                        endcase
                        r.ch    = pos[0] ? dig(ln, 0) : dig(ln, 1);
                        r.start = (pos == 5'd0);
                        r.len   = 4'd2;
                        r.fin   = (pos == 5'd1);
                    end
                    CODE_LJ: begin
                        r.ch    = (pos == 5'd0) ? dig(L_YDAY, 2) :
                                  (pos == 5'd1) ? dig(L_YDAY, 1) : dig(L_YDAY, 0);
                        r.start = (pos == 5'd0);
                        r.len   = 4'd3;
                        r.fin   = (pos == 5'd2);
                    end
                    CODE_UY: begin
                        r.ch    = dig(L_YEAR, 3 - int'(pos[1:0]));
                        r.start = (pos == 5'd0);
                        r.len   = 4'd4;
                        r.fin   = (pos == 5'd3);
                    end
                    CODE_LW: begin
                        r.ch = CH_ZERO + {5'd0, r_wday}; r.start = 1'b1; r.fin = 1'b1;
                    end
                    CODE_LP: begin
                        r.ch    = pos[0] ? CH_UPPER_M :
                                  ((r_hour < 5'd12) ? CH_UPPER_A : CH_UPPER_P);
                        r.start = (pos == 5'd0);
                        r.len   = 4'd2;
                        r.fin   = (pos == 5'd1);
                    end
                    CODE_UZ: begin
                        r.ch    = name_byte({"UTC", 48'h0}, pos[3:0]);
                        r.start = (pos == 5'd0);
                        r.len   = 4'd3;
                        r.fin   = (pos == 5'd2);
                    end
                    CODE_LC: begin
                        case (pos)
                            5'd0:  begin r.ch = name_byte(w_day_str, 4'd0);
                                   r.start = 1'b1; r.len = 4'd3; end
                            5'd1:  r.ch = name_byte(w_day_str, 4'd1);
                            5'd2:  r.ch = name_byte(w_day_str, 4'd2);
                            5'd3:  r.start = 1'b1;
                            5'd4:  begin r.ch = name_byte(w_mon_str, 4'd0);
                                   r.start = 1'b1; r.len = 4'd3; end
                            5'd5:  r.ch = name_byte(w_mon_str, 4'd1);
                            5'd6:  r.ch = name_byte(w_mon_str, 4'd2);
                            5'd7:  r.start = 1'b1;
                            5'd8:  begin r.ch = dig(L_MDAY, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd9:  r.ch = dig(L_MDAY, 0);
                            5'd10: r.start = 1'b1;
                            5'd11: begin r.ch = dig(L_HOUR, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd12: r.ch = dig(L_HOUR, 0);
                            5'd13: begin r.ch = CH_COLON; r.start = 1'b1; end
                            5'd14: begin r.ch = dig(L_MIN, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd15: r.ch = dig(L_MIN, 0);
                            5'd16: begin r.ch = CH_COLON; r.start = 1'b1; end
                            5'd17: begin r.ch = dig(L_SEC, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd18: r.ch = dig(L_SEC, 0);
                            5'd19: r.start = 1'b1;
                            5'd20: begin r.ch = dig(L_YEAR, 3); r.start = 1'b1; r.len = 4'd4; end
                            5'd21: r.ch = dig(L_YEAR, 2);
                            5'd22: r.ch = dig(L_YEAR, 1);
                            default: begin r.ch = dig(L_YEAR, 0); r.fin = 1'b1; end
                        endcase
                    end
                    CODE_LX: begin
                        case (pos)
                            5'd0:  begin r.ch = name_byte(w_day_str, 4'd0);
                                   r.start = 1'b1; r.len = 4'd3; end
                            5'd1:  r.ch = name_byte(w_day_str, 4'd1);
                            5'd2:  r.ch = name_byte(w_day_str, 4'd2);
                            5'd3:  r.start = 1'b1;
                            5'd4:  begin r.ch = name_byte(w_mon_str, 4'd0);
                                   r.start = 1'b1; r.len = 4'd3; end
                            5'd5:  r.ch = name_byte(w_mon_str, 4'd1);
                            5'd6:  r.ch = name_byte(w_mon_str, 4'd2);
                            5'd7:  r.start = 1'b1;
                            5'd8:  begin r.ch = dig(L_MDAY, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd9:  r.ch = dig(L_MDAY, 0);
                            5'd10: begin r.ch = CH_COMMA; r.start = 1'b1; r.len = 4'd2; end
                            5'd11: r.ch = CH_SPACE;
                            5'd12: begin r.ch = dig(L_YEAR, 3); r.start = 1'b1; r.len = 4'd4; end
                            5'd13: r.ch = dig(L_YEAR, 2);
                            5'd14: r.ch = dig(L_YEAR, 1);
                            default: begin r.ch = dig(L_YEAR, 0); r.fin = 1'b1; end
                        endcase
                    end
                    CODE_UX: begin
                        case (pos)
                            5'd0:  begin r.ch = dig(L_HOUR, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd1:  r.ch = dig(L_HOUR, 0);
                            5'd2:  begin r.ch = CH_COLON; r.start = 1'b1; end
                            5'd3:  begin r.ch = dig(L_MIN, 1); r.start = 1'b1; r.len = 4'd2; end
                            5'd4:  r.ch = dig(L_MIN, 0);
                            5'd5:  begin r.ch = CH_COLON; r.start = 1'b1; end
                            5'd6:  begin r.ch = dig(L_SEC, 1); r.start = 1'b1; r.len = 4'd2; end
                            default: begin r.ch = dig(L_SEC, 0); r.fin = 1'b1; end
                        endcase
                    end
                    default: begin
                        r.ch    = pos[0] ? r_code : CODE_PCT;
                        r.start = (pos == 5'd0);
                        r.len   = 4'd2;
                        r.fin   = (pos == 5'd1);
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    always_comb begin
        w_cur = info_at(r_pos);
        w_nxt = info_at(r_pos + 5'd1);
        w_fit = !w_cur.start || (!r_ovf && ({12'd0, w_cur.len} < r_room));
        w_room_after = w_cur.start ? r_room - {12'd0, w_cur.len} : r_room;
        w_emit_char  = i_cmd.emit && w_fit;
    end

    always_comb begin
        o_st.go_conv   = w_acc && (w_op == OP_BEGIN);
        o_st.go_emit   = w_acc && (((w_op == OP_CHAR) && (r_pending || (w_ch != CODE_PCT)))
                                   || ((w_op == OP_END) && r_pending));
        o_st.go_report = w_acc && (w_op == OP_END) && !r_pending;
        o_st.conv_busy = |w_busy;
        o_st.out_free  = !r_out_valid || i_m_tready;
        o_st.step_end  = !w_fit || w_cur.fin;
        o_st.to_report = (r_mode == MODE_DANGLE);
    end

    // Held time fields keep their reset values until the first begin item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= 6'd0;  r_min  <= 6'd0;  r_hour <= 5'd0; r_mday <= 5'd1;
            r_mon  <= 4'd0;  r_year <= 13'd0; r_wday <= 3'd0; r_yday <= 9'd0;
        end else if (w_acc && (w_op == OP_BEGIN)) begin
            r_sec  <= i_s_tdata[13:8];
            r_min  <= i_s_tdata[19:14];
            r_hour <= i_s_tdata[24:20];
            r_mday <= i_s_tdata[29:25];
            r_mon  <= i_s_tdata[33:30];
            r_year <= i_s_tdata[46:34];
            r_wday <= i_s_tdata[49:47];
            r_yday <= i_s_tdata[58:50];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= 16'd0;
            r_room    <= 16'd0;
            r_pending <= 1'b0;
            r_ovf     <= 1'b0;
            r_mode    <= MODE_LIT;
            r_pos     <= 5'd0;
        end else if (w_acc) begin
            case (w_op)
                OP_BEGIN: begin
                    r_cap     <= i_s_tdata[74:59];
                    r_room    <= i_s_tdata[74:59];
                    r_pending <= 1'b0;
                    r_ovf     <= 1'b0;
                end
                OP_CHAR: begin
                    r_pos <= 5'd0;
                    if (r_pending) begin
                        r_pending <= 1'b0;
                        r_mode    <= MODE_EXP;
                    end else if (w_ch == CODE_PCT) begin
                        r_pending <= 1'b1;
                    end else begin
                        r_mode <= MODE_LIT;
                    end
                end
                OP_END: begin
                    r_pos <= 5'd0;
                    if (r_pending) begin
                        r_pending <= 1'b0;
                        r_mode    <= MODE_DANGLE;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + 5'd1;
            if (!w_fit) begin
                r_ovf <= 1'b1;
            end else begin
                r_room <= w_room_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_op == OP_CHAR)) begin
            r_code <= w_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_char || i_cmd.report) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_char) begin
            r_out_kind <= KIND_CHAR;
            r_out_char <= w_cur.ch;
            r_out_len  <= 16'd0;
            r_out_ovf  <= 1'b0;
            // Last of the item unless a percent dangles: when the piece list ends or the next piece will not fit.
            r_out_last <= (r_mode != MODE_DANGLE) &&
                          (w_cur.fin || (w_nxt.start && ({12'd0, w_nxt.len} >= w_room_after)));
        end else if (i_cmd.report) begin
            r_out_kind <= KIND_REPORT;
            r_out_char <= 8'd0;
            r_out_len  <= r_ovf ? 16'd0 : r_cap - r_room;
            r_out_ovf  <= r_ovf;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_ovf, r_out_len, r_out_char};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

### design/date_time_format_expander.sv
// Date and time formatter in the style of strftime, fed one format byte per request.
// The slave channel takes requests; tuser holds the opcode: begin (load the
// broken-down time and buffer size), format character, or end of format.
// The master channel returns results; tuser is the kind (character or length
// report) and tlast marks the last result caused by one request.
// Reset returns the held time to its reset values and then runs the decimal
// conversion (start, 14 steps, exit) before the first request is taken; a
// begin request runs the same conversion (accept, start, 14 steps, exit).
// A format character is accepted and then emits its characters one by one
// (up to 24 for the date-and-time layout); a piece that does not fit sets the
// overflow flag and ends the expansion. An end request yields the length
// report, preceded by a percent sign when one is pending.
// The rate is set by the single output register: one character per cycle
// while the receiver takes each result. When the receiver stalls, the output
// register holds its result and the expansion waits; a new request is still
// accepted while the last result of the previous one waits to be taken.
module date_time_format_expander
    import dtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // code_char, second, minute, hour, day_of_month, month_index,
    // years_since_base, weekday, day_of_year, buffer_size, zero padding
    input  logic [79:0] i_s_tdata,
    // op
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_char, final_length, overflowed, zero padding
    output logic [31:0] o_m_tdata,
    // kind
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    t_cmd    w_cmd;
    t_status w_st;

    // The controller sequences conversion, expansion and report.
    dtf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the time, the room counter and the output register.
    dtf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready = w_cmd.in_ready;

endmodule

### design/dtf_checker.sv
module dtf_checker
    import dtf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_REPORT) |-> o_m_tlast)
        else $error("length report not last of its request");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_CHAR) |-> !o_m_tdata[24] && (o_m_tdata[23:8] == 16'd0))
        else $error("character result carries overflow or length");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_REPORT) && o_m_tdata[24] |-> o_m_tdata[23:8] == 16'd0)
        else $error("overflowed report with nonzero length");

endmodule

bind date_time_format_expander dtf_checker u_dtf_checker (.*);
